### hw/rtl/lebuf_pkg.sv
package lebuf_pkg;

  typedef enum logic [2:0] {
    OP_INSERT    = 3'd0,
    OP_BACKSPACE = 3'd1,
    OP_HOME      = 3'd2,
    OP_END       = 3'd3,
    OP_LEFT      = 3'd4,
    OP_RIGHT     = 3'd5,
    OP_DELETE    = 3'd6,
    OP_SUBMIT    = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_CHAR   = 2'd1,
    KIND_EMPTY  = 2'd2
  } kind_t;

  localparam logic [7:0] PRINTABLE_MIN = 8'h20;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] char_out;
    logic [5:0] cursor_pos;
    logic [5:0] line_length;
    logic       accepted;
    logic       last;
  } result_t;

endpackage

### hw/rtl/lebuf_mem.sv
module lebuf_mem #(
  parameter int DEPTH = 63,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/lebuf_ctrl.sv
module lebuf_ctrl #(
  parameter int LINE_CAPACITY = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_op,
  input  logic [7:0]          in_key,
  output logic                res_valid,
  input  logic                res_ready,
  output lebuf_pkg::result_t  res
);

  localparam int LW    = $clog2(LINE_CAPACITY);
  localparam int DEPTH = LINE_CAPACITY - 1;
  localparam int AW    = (LINE_CAPACITY > 2) ? $clog2(LINE_CAPACITY - 1) : 1;
  localparam logic [LW-1:0] MAX_LEN = LW'(LINE_CAPACITY - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_FIN,
    S_EMIT,
    S_SUB_RD,
    S_SUB_EM
  } state_t;

  state_t              state;
  logic [LW-1:0]       cursor;
  logic [LW-1:0]       length;
  logic [LW-1:0]       cnt;
  logic [LW-1:0]       ptr;
  logic                dir_right;
  logic                pend;
  logic [AW-1:0]       pend_addr;
  logic                acc;
  lebuf_pkg::kind_t    kind;
  lebuf_pkg::op_t      op;
  logic [7:0]          key;

  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [7:0]          mem_wdata;
  logic                mem_re;
  logic [AW-1:0]       mem_raddr;
  logic [7:0]          mem_rdata;
  logic                sub_last;

  lebuf_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_ready = (state == S_IDLE);
  assign sub_last = (ptr == cnt - LW'(1));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pend_addr;
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = AW'(ptr);
    res_valid = 1'b0;
    res.kind        = kind;
    res.char_out    = 8'd0;
    res.cursor_pos  = 6'(cursor);
    res.line_length = 6'(length);
    res.accepted    = acc;
    res.last        = 1'b1;
    unique case (state)
      S_SHIFT: begin
        mem_re    = (cnt != '0);
        mem_we    = pend;
        mem_waddr = dir_right ? pend_addr + AW'(1) : pend_addr - AW'(1);
      end
      S_FIN: begin
        mem_we    = (op == lebuf_pkg::OP_INSERT);
        mem_waddr = AW'(cursor);
        mem_wdata = key;
      end
      S_EMIT: begin
        res_valid = 1'b1;
      end
      S_SUB_RD: begin
        mem_re = 1'b1;
      end
      S_SUB_EM: begin
        res_valid    = 1'b1;
        res.kind     = lebuf_pkg::KIND_CHAR;
        res.char_out = mem_rdata;
        res.last     = sub_last;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cursor <= '0;
      length <= '0;
      pend   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op    <= lebuf_pkg::op_t'(in_op);
            key   <= in_key;
            acc   <= 1'b1;
            kind  <= lebuf_pkg::KIND_STATUS;
            pend  <= 1'b0;
            state <= S_EMIT;
            unique case (lebuf_pkg::op_t'(in_op))
              lebuf_pkg::OP_INSERT: begin
                if (in_key >= lebuf_pkg::PRINTABLE_MIN && length != MAX_LEN) begin
                  cnt       <= length - cursor;
                  ptr       <= length - LW'(1);
                  dir_right <= 1'b1;
                  state     <= S_SHIFT;
                end else begin
                  acc <= 1'b0;
                end
              end
              lebuf_pkg::OP_BACKSPACE: begin
                if (cursor != '0) begin
                  cnt       <= length - cursor;
                  ptr       <= cursor;
                  dir_right <= 1'b0;
                  state     <= S_SHIFT;
                end
              end
              lebuf_pkg::OP_HOME: cursor <= '0;
              lebuf_pkg::OP_END:  cursor <= length;
              lebuf_pkg::OP_LEFT: begin
                if (cursor != '0) cursor <= cursor - LW'(1);
              end
              lebuf_pkg::OP_RIGHT: begin
                if (cursor < length) cursor <= cursor + LW'(1);
              end
              lebuf_pkg::OP_DELETE: begin
                if (cursor < length) begin
                  cnt       <= length - cursor - LW'(1);
                  ptr       <= cursor + LW'(1);
                  dir_right <= 1'b0;
                  state     <= S_SHIFT;
                end
              end
              lebuf_pkg::OP_SUBMIT: begin
                cnt    <= length;
                ptr    <= '0;
                cursor <= '0;
                length <= '0;
                if (length == '0) begin
                  kind <= lebuf_pkg::KIND_EMPTY;
                end else begin
                  state <= S_SUB_RD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_SHIFT: begin
          // one read a cycle; the previous read's byte lands one slot over
          if (cnt != '0) begin
            cnt       <= cnt - LW'(1);
            ptr       <= dir_right ? ptr - LW'(1) : ptr + LW'(1);
            pend      <= 1'b1;
            pend_addr <= AW'(ptr);
          end else begin
            pend  <= 1'b0;
            state <= S_FIN;
          end
        end
        S_FIN: begin
          unique case (op)
            lebuf_pkg::OP_INSERT: begin
              cursor <= cursor + LW'(1);
              length <= length + LW'(1);
            end
            lebuf_pkg::OP_BACKSPACE: begin
              cursor <= cursor - LW'(1);
              length <= length - LW'(1);
            end
            default: length <= length - LW'(1);
          endcase
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (res_ready) state <= S_IDLE;
        end
        S_SUB_RD: begin
          state <= S_SUB_EM;
        end
        S_SUB_EM: begin
          if (res_ready) begin
            ptr   <= ptr + LW'(1);
            state <= sub_last ? S_IDLE : S_SUB_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/lebuf_out.sv
module lebuf_out (
  input  logic               clk,
  input  logic               rst,
  input  logic               res_valid,
  output logic               res_ready,
  input  lebuf_pkg::result_t res,
  output logic               out_valid,
  input  logic               out_ready,
  output lebuf_pkg::result_t out_res
);

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  // hold the result until the downstream transaction completes
  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

endmodule

### hw/rtl/line_edit_buffer_core.sv
// Single-line editor with a cursor: each input transaction is one key operation
// (operation in s_tuser, key byte in s_tdata) and the line lives in a one-port-read,
// one-port-write RAM of LINE_CAPACITY-1 bytes. An insert, backspace or delete that
// changes the line moves the tail one byte a cycle through the RAM before its result;
// every other key, including an edit with nothing to do, gives its result without the
// RAM. Submit streams the line a character at a time (RAM read, then output), with
// tlast on the final character, or returns one empty-line result. Each result sits
// in an output register, so the next key is taken while a result waits on m_tready;
// a further result held up by m_tready stalls the block. Stored bytes need no reset;
// only entries below the current length are ever read.
module line_edit_buffer_core #(
  parameter int LINE_CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] key_byte
  input  logic [2:0]  s_tuser,   // [2:0] operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] char_out, [13:8] cursor_pos,
                                 // [19:14] line_length, [20] accepted, [23:21] zero
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast
);

  logic               res_valid;
  logic               res_ready;
  lebuf_pkg::result_t res;
  lebuf_pkg::result_t out_res;

  lebuf_ctrl #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_op     (s_tuser),
    .in_key    (s_tdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  lebuf_out u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tdata = {3'b000, out_res.accepted, out_res.line_length,
                    out_res.cursor_pos, out_res.char_out};
  assign m_tuser = out_res.kind;
  assign m_tlast = out_res.last;

`ifndef SYNTH
  a_cursor_le_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == lebuf_pkg::KIND_STATUS |-> m_tdata[13:8] <= m_tdata[19:14])
    else $error("status cursor beyond line length");

  a_submit_cleared: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == lebuf_pkg::KIND_CHAR || m_tuser == lebuf_pkg::KIND_EMPTY)
    |-> m_tdata[19:8] == 12'd0)
    else $error("submit result with nonzero cursor or length");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == lebuf_pkg::KIND_EMPTY |-> m_tlast && m_tdata[7:0] == 8'd0)
    else $error("empty-line result malformed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while previous key still in progress");
`endif

endmodule
